>>> hdl/rimc_pkg.sv
`default_nettype none

package rimc_pkg;

	// Table geometry
	localparam int NumClasses = 41;
	localparam int ClsW       = 6;
	localparam int CtrW       = 64;
	localparam int CostW      = 16;
	localparam int OutW       = 64;
	localparam int EntryW     = 2 * CtrW;

	// Request kinds
	typedef enum logic {
		REQ_RECORD = 1'b0,
		REQ_READ   = 1'b1
	} req_kind_t;

	// Opcodes
	localparam logic [6:0] OP_REG    = 7'b0110011;
	localparam logic [6:0] OP_IMM    = 7'b0010011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_SYSTEM = 7'b1110011;
	localparam logic [6:0] OP_FENCE  = 7'b0001111;

	// funct3 codes with a special meaning
	localparam logic [2:0] F3_ADD = 3'b000;
	localparam logic [2:0] F3_SR  = 3'b101;

	// System immediates
	localparam logic [11:0] F12_ECALL  = 12'h000;
	localparam logic [11:0] F12_EBREAK = 12'h001;

	// Class codes
	localparam logic [ClsW-1:0] CLS_LUI     = ClsW'(0);
	localparam logic [ClsW-1:0] CLS_AUIPC   = ClsW'(1);
	localparam logic [ClsW-1:0] CLS_JAL     = ClsW'(2);
	localparam logic [ClsW-1:0] CLS_JALR    = ClsW'(3);
	localparam logic [ClsW-1:0] CLS_BEQ     = ClsW'(4);
	localparam logic [ClsW-1:0] CLS_BNE     = ClsW'(5);
	localparam logic [ClsW-1:0] CLS_BLT     = ClsW'(6);
	localparam logic [ClsW-1:0] CLS_BGE     = ClsW'(7);
	localparam logic [ClsW-1:0] CLS_BLTU    = ClsW'(8);
	localparam logic [ClsW-1:0] CLS_BGEU    = ClsW'(9);
	localparam logic [ClsW-1:0] CLS_LB      = ClsW'(10);
	localparam logic [ClsW-1:0] CLS_LH      = ClsW'(11);
	localparam logic [ClsW-1:0] CLS_LW      = ClsW'(12);
	localparam logic [ClsW-1:0] CLS_LBU     = ClsW'(13);
	localparam logic [ClsW-1:0] CLS_LHU     = ClsW'(14);
	localparam logic [ClsW-1:0] CLS_SB      = ClsW'(15);
	localparam logic [ClsW-1:0] CLS_SH      = ClsW'(16);
	localparam logic [ClsW-1:0] CLS_SW      = ClsW'(17);
	localparam logic [ClsW-1:0] CLS_ADDI    = ClsW'(18);
	localparam logic [ClsW-1:0] CLS_SLTI    = ClsW'(19);
	localparam logic [ClsW-1:0] CLS_SLTIU   = ClsW'(20);
	localparam logic [ClsW-1:0] CLS_XORI    = ClsW'(21);
	localparam logic [ClsW-1:0] CLS_ORI     = ClsW'(22);
	localparam logic [ClsW-1:0] CLS_ANDI    = ClsW'(23);
	localparam logic [ClsW-1:0] CLS_SLLI    = ClsW'(24);
	localparam logic [ClsW-1:0] CLS_SRLI    = ClsW'(25);
	localparam logic [ClsW-1:0] CLS_SRAI    = ClsW'(26);
	localparam logic [ClsW-1:0] CLS_ADD     = ClsW'(27);
	localparam logic [ClsW-1:0] CLS_SUB     = ClsW'(28);
	localparam logic [ClsW-1:0] CLS_SLL     = ClsW'(29);
	localparam logic [ClsW-1:0] CLS_SLT     = ClsW'(30);
	localparam logic [ClsW-1:0] CLS_SLTU    = ClsW'(31);
	localparam logic [ClsW-1:0] CLS_XOR     = ClsW'(32);
	localparam logic [ClsW-1:0] CLS_SRL     = ClsW'(33);
	localparam logic [ClsW-1:0] CLS_SRA     = ClsW'(34);
	localparam logic [ClsW-1:0] CLS_OR      = ClsW'(35);
	localparam logic [ClsW-1:0] CLS_AND     = ClsW'(36);
	localparam logic [ClsW-1:0] CLS_FENCE   = ClsW'(37);
	localparam logic [ClsW-1:0] CLS_ECALL   = ClsW'(38);
	localparam logic [ClsW-1:0] CLS_EBREAK  = ClsW'(39);
	localparam logic [ClsW-1:0] CLS_INVALID = ClsW'(40);

	// Channel payloads
	typedef struct packed {
		req_kind_t         req_type;
		logic [31:0]       instr_word;
		logic [CostW-1:0]  cycle_cost;
		logic [ClsW-1:0]   class_index;
	} req_beat_t;

	typedef struct packed {
		logic [ClsW-1:0] class_code;
		logic [OutW-1:0] class_count;
		logic [OutW-1:0] class_cycles;
		logic [OutW-1:0] total_issued;
	} rsp_beat_t;

	// Map an instruction word to its class
	function automatic logic [ClsW-1:0] classify(input logic [31:0] w);
		logic [6:0]      op;
		logic [2:0]      f3;
		logic [6:0]      f7;
		logic [11:0]     f12;
		logic [ClsW-1:0] c;
		op  = w[6:0];
		f3  = w[14:12];
		f7  = w[31:25];
		f12 = w[31:20];
		c   = CLS_INVALID;
		unique case (op)
			OP_REG: begin
				if (f3 == F3_ADD && f7 != 7'd0) begin
					c = CLS_SUB;
				end else if (f3 == F3_SR && f7 != 7'd0) begin
					c = CLS_SRA;
				end else begin
					unique case (f3)
						3'd0: c = CLS_ADD;
						3'd1: c = CLS_SLL;
						3'd2: c = CLS_SLT;
						3'd3: c = CLS_SLTU;
						3'd4: c = CLS_XOR;
						3'd5: c = CLS_SRL;
						3'd6: c = CLS_OR;
						default: c = CLS_AND;
					endcase
				end
			end
			OP_IMM: begin
				if (f3 == F3_SR && f7 != 7'd0) begin
					c = CLS_SRAI;
				end else begin
					unique case (f3)
						3'd0: c = CLS_ADDI;
						3'd1: c = CLS_SLLI;
						3'd2: c = CLS_SLTI;
						3'd3: c = CLS_SLTIU;
						3'd4: c = CLS_XORI;
						3'd5: c = CLS_SRLI;
						3'd6: c = CLS_ORI;
						default: c = CLS_ANDI;
					endcase
				end
			end
			OP_LOAD: begin
				unique case (f3)
					3'd0: c = CLS_LB;
					3'd1: c = CLS_LH;
					3'd2: c = CLS_LW;
					3'd4: c = CLS_LBU;
					3'd5: c = CLS_LHU;
					default: c = CLS_INVALID;
				endcase
			end
			OP_STORE: begin
				unique case (f3)
					3'd0: c = CLS_SB;
					3'd1: c = CLS_SH;
					3'd2: c = CLS_SW;
					default: c = CLS_INVALID;
				endcase
			end
			OP_BRANCH: begin
				unique case (f3)
					3'd0: c = CLS_BEQ;
					3'd1: c = CLS_BNE;
					3'd4: c = CLS_BLT;
					3'd5: c = CLS_BGE;
					3'd6: c = CLS_BLTU;
					3'd7: c = CLS_BGEU;
					default: c = CLS_INVALID;
				endcase
			end
			OP_LUI:   c = CLS_LUI;
			OP_AUIPC: c = CLS_AUIPC;
			OP_JAL:   c = CLS_JAL;
			OP_JALR:  c = CLS_JALR;
			OP_SYSTEM: begin
				if (f12 == F12_ECALL) begin
					c = CLS_ECALL;
				end else if (f12 == F12_EBREAK) begin
					c = CLS_EBREAK;
				end else begin
					c = CLS_INVALID;
				end
			end
			OP_FENCE: c = CLS_FENCE;
			default:  c = CLS_INVALID;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hdl/rimc_ram.sv
`default_nettype none

module rimc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/rv32i_instruction_mix_counter.sv
`default_nettype none

// Channel  Handshake             Payload
// req      req_valid/req_stall   rimc_pkg::req_beat_t (record or read)
// rsp      rsp_valid/rsp_stall   rimc_pkg::rsp_beat_t (class, counters, total)
//
// One beat per cycle while the response is not stalled: a request reads its
// class entry from the counter RAM at acceptance; in the update stage a record
// writes back the updated entry and the response is loaded into the output
// register. A write to the entry being read in the same cycle is forwarded.
// Reset clears per-entry valid bits and the grand total; no clearing pass.
// A stalled response holds the update stage, which then stalls requests.

module rv32i_instruction_mix_counter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire rimc_pkg::req_beat_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output rimc_pkg::rsp_beat_t      rsp
);

	localparam int NumClasses = rimc_pkg::NumClasses;
	localparam int ClsW       = rimc_pkg::ClsW;
	localparam int CtrW       = rimc_pkg::CtrW;
	localparam int CostW      = rimc_pkg::CostW;
	localparam int OutW       = rimc_pkg::OutW;
	localparam int EntryW     = rimc_pkg::EntryW;
	localparam int AddrW      = $clog2(NumClasses);

	// Update stage
	logic                  v_s1;
	rimc_pkg::req_kind_t   kind_s1;
	logic [ClsW-1:0]       code_s1;
	logic [AddrW-1:0]      addr_s1;
	logic                  inr_s1;
	logic [CostW-1:0]      cost_s1;
	logic                  fwd_s1;
	logic [EntryW-1:0]     fwd_data_s1;

	logic [NumClasses-1:0] valid_q;
	logic [CtrW-1:0]       total_q;
	logic                  out_v_q;
	rimc_pkg::rsp_beat_t   out_q;

	logic                  accept;
	logic                  advance;
	logic                  wr_en;
	logic [ClsW-1:0]       dec_code;
	logic [ClsW-1:0]       in_code;
	logic                  in_inr;
	logic [AddrW-1:0]      in_addr;
	logic [EntryW-1:0]     ram_rdata;
	logic [EntryW-1:0]     cur_entry;
	logic [CtrW-1:0]       cur_cnt;
	logic [CtrW-1:0]       cur_cyc;
	logic [CtrW-1:0]       new_cnt;
	logic [CtrW-1:0]       new_cyc;
	logic [CtrW-1:0]       new_total;
	logic [EntryW-1:0]     new_entry;

	// Handshake
	assign advance   = v_s1 && (!out_v_q || !rsp_stall);
	assign req_stall = v_s1 && !advance;
	assign accept    = req_valid && !req_stall;
	assign wr_en     = advance && (kind_s1 == rimc_pkg::REQ_RECORD);

	// Decode the request: class to touch and whether it exists
	always_comb begin
		dec_code = rimc_pkg::classify(req.instr_word);
		if (req.req_type == rimc_pkg::REQ_RECORD) begin
			in_code = dec_code;
			in_inr  = 1'b1;
		end else begin
			in_code = req.class_index;
			in_inr  = (req.class_index < ClsW'(NumClasses));
		end
		in_addr = in_inr ? in_code[AddrW-1:0] : '0;
	end

	rimc_ram #(
		.WIDTH(EntryW),
		.DEPTH(NumClasses)
	) u_ctr_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(new_entry),
		.re   (accept),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	// Pick the current entry: forwarded, stored, or reset value
	always_comb begin
		if (fwd_s1) begin
			cur_entry = fwd_data_s1;
		end else if (valid_q[addr_s1]) begin
			cur_entry = ram_rdata;
		end else begin
			cur_entry = '0;
		end
		cur_cnt   = cur_entry[EntryW-1:CtrW];
		cur_cyc   = cur_entry[CtrW-1:0];
		new_cnt   = cur_cnt + CtrW'(1);
		new_cyc   = cur_cyc + CtrW'(cost_s1);
		new_total = total_q + CtrW'(1);
		new_entry = {new_cnt, new_cyc};
	end

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1   <= 1'b1;
				fwd_s1 <= wr_en && (addr_s1 == in_addr);
			end else if (advance) begin
				v_s1   <= 1'b0;
				fwd_s1 <= 1'b0;
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= req.req_type;
			code_s1     <= in_code;
			addr_s1     <= in_addr;
			inr_s1      <= in_inr;
			cost_s1     <= req.cycle_cost;
			fwd_data_s1 <= new_entry;
		end
	end

	// Entry valid bits and grand total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
		end else if (wr_en) begin
			valid_q[addr_s1] <= 1'b1;
			total_q          <= new_total;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_v_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.class_code <= code_s1;
			if (kind_s1 == rimc_pkg::REQ_RECORD) begin
				out_q.class_count  <= OutW'(new_cnt);
				out_q.class_cycles <= OutW'(new_cyc);
				out_q.total_issued <= OutW'(new_total);
			end else begin
				out_q.class_count  <= inr_s1 ? OutW'(cur_cnt) : '0;
				out_q.class_cycles <= inr_s1 ? OutW'(cur_cyc) : '0;
				out_q.total_issued <= OutW'(total_q);
			end
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire
